// ===== rtl/ncd_pkg.sv =====
// Package for the nibble count code decoder.
// Holds the decoder state and result types and the per-nibble decode function.
// No dependencies.
package ncd_pkg;

  localparam int unsigned COUNT_W    = 16;
  localparam int unsigned RES_DEPTH  = 4;
  localparam int unsigned RES_PTR_W  = $clog2(RES_DEPTH);
  localparam int unsigned RES_CNT_W  = $clog2(RES_DEPTH + 1);

  // code tiers
  localparam logic [1:0] TIER_IDLE = 2'd0;
  localparam logic [1:0] TIER_BYTE = 2'd1;
  localparam logic [1:0] TIER_WORD = 2'd2;
  localparam logic [1:0] TIER_RSVD = 2'd3;  // unused, treated as idle

  localparam logic [3:0] NIB_ESC     = 4'hF;
  localparam logic [7:0] BYTE_ESC    = 8'hFF;
  localparam logic [COUNT_W-1:0] SHORT_BIAS = 16'd2;
  localparam logic [COUNT_W-1:0] BYTE_BIAS  = 16'd17;
  localparam logic [2:0] BYTE_NIBS   = 3'd2;
  localparam logic [2:0] WORD_NIBS   = 3'd4;

  typedef struct packed {
    logic [1:0]         tier;
    logic [2:0]         left;
    logic [COUNT_W-1:0] acc;
  } dec_state_t;

  typedef struct packed {
    dec_state_t         st;
    logic               done;
    logic [COUNT_W-1:0] count;
  } nib_res_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               status;
    logic               last;
  } res_t;

  localparam dec_state_t STATE_RESET = '{tier: TIER_IDLE, left: 3'd0, acc: '0};

  function automatic logic state_open(input dec_state_t st);
    logic idle;
    idle = (st.tier == TIER_IDLE) || (st.tier == TIER_RSVD) || (st.left == 3'd0);
    return !idle;
  endfunction

  // One nibble through the code state.
  function automatic nib_res_t take_nibble(input dec_state_t st, input logic [3:0] nib);
    nib_res_t r;
    logic [COUNT_W-1:0] acc_n;
    logic [2:0] left_n;
    r.st    = st;
    r.done  = 1'b0;
    r.count = '0;
    acc_n   = {st.acc[COUNT_W-5:0], nib};
    left_n  = st.left - 3'd1;
    if (!state_open(st)) begin
      if (nib != NIB_ESC) begin
        r.st    = STATE_RESET;
        r.done  = 1'b1;
        r.count = {12'd0, nib} + SHORT_BIAS;
      end else begin
        r.st = '{tier: TIER_BYTE, left: BYTE_NIBS, acc: '0};
      end
    end else if (left_n != 3'd0) begin
      r.st = '{tier: st.tier, left: left_n, acc: acc_n};
    end else if (st.tier == TIER_BYTE) begin
      if (acc_n[7:0] != BYTE_ESC) begin
        r.st    = STATE_RESET;
        r.done  = 1'b1;
        r.count = {8'd0, acc_n[7:0]} + BYTE_BIAS;
      end else begin
        r.st = '{tier: TIER_WORD, left: WORD_NIBS, acc: '0};
      end
    end else begin
      r.st    = STATE_RESET;
      r.done  = 1'b1;
      r.count = acc_n;
    end
    return r;
  endfunction

endpackage

// ===== rtl/nibble_count_code_decoder_top.sv =====
// Top level of the nibble count code decoder.
// Depends on ncd_pkg, ncd_decode and ncd_result_fifo.
//
//  channel | dir | handshake               | payload
//  --------+-----+-------------------------+------------------------------------
//  in      | in  | in_valid_i / in_ready_o | data_byte_i[7:0], last_byte_i
//  out     | out | out_valid_o/out_ready_i | run_count_o[15:0], status_o,
//          |     |                         | run_last_o
//
// Flow: a word is registered on accept in the input stage, decoded (both
//   nibbles) from there once the queue has room for two, and its 0..2 results
//   are written into a 4-entry result queue, from which they are presented on
//   the output port. One input word per cycle while the queue has room;
//   sustained rate is bounded by the output port, one result per cycle.
// Reset: async active low; clears code state, input stage and queue pointers.
// Stalls: the input stage drains into the queue only when two slots are free,
//   so in_ready_o drops once the queue backs up.
module nibble_count_code_decoder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] run_count_o,
  output logic        status_o,
  output logic        run_last_o
);
  import ncd_pkg::*;

  // input register stage
  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;

  logic       room2;
  logic       fire;        // decode the staged word this cycle
  res_t       res0, res1, head;
  logic [1:0] num;
  logic [RES_CNT_W-1:0] fill;

  assign fire       = in_vld_q && room2;
  assign in_ready_o = !in_vld_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= data_byte_i;
      in_last_q <= last_byte_i;
    end
  end

  ncd_decode u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .byte_i (in_byte_q),
    .last_i (in_last_q),
    .res0_o (res0),
    .res1_o (res1),
    .num_o  (num)
  );

  ncd_result_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_num_i (fire ? num : 2'd0),
    .push0_i    (res0),
    .push1_i    (res1),
    .room2_o    (room2),
    .valid_o    (out_valid_o),
    .ready_i    (out_ready_i),
    .head_o     (head),
    .fill_o     (fill)
  );

  assign run_count_o = head.count;
  assign status_o    = head.status;
  assign run_last_o  = head.last;

  // queue never overfills
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill <= RES_CNT_W'(RES_DEPTH))
    else $error("result queue overfilled");

  // a truncation word is always the last of its byte and carries no count
  a_trunc_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> run_last_o && (run_count_o == '0))
    else $error("malformed truncation word");

  // a staged word is only held back when the queue lacks room
  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !fire |-> !room2)
    else $error("input stage stalled with room in queue");

  // a decoded word never yields more than two results
  a_num_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |-> num != 2'd3)
    else $error("decode produced too many results");

endmodule

// ===== rtl/ncd_decode.sv =====
// Decode stage: code state register and two-nibble decode of one byte.
// Depends on ncd_pkg.
module ncd_decode (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          fire_i,
  input  logic [7:0]    byte_i,
  input  logic          last_i,
  output ncd_pkg::res_t res0_o,
  output ncd_pkg::res_t res1_o,
  output logic [1:0]    num_o
);
  import ncd_pkg::*;

  dec_state_t st_q, st_d;
  nib_res_t   r0, r1;
  logic       trunc;
  res_t       tr_res;

  assign r0     = take_nibble(st_q, byte_i[7:4]);
  assign r1     = take_nibble(r0.st, byte_i[3:0]);
  assign trunc  = last_i && state_open(r1.st);
  assign tr_res = '{count: '0, status: 1'b1, last: 1'b1};

  always_comb begin
    res0_o = '{count: r0.count, status: 1'b0, last: 1'b0};
    res1_o = '{count: r1.count, status: 1'b0, last: 1'b1};
    num_o  = 2'd0;
    if (r0.done) begin
      if (r1.done) begin
        num_o = 2'd2;
      end else if (trunc) begin
        res1_o = tr_res;
        num_o  = 2'd2;
      end else begin
        res0_o.last = 1'b1;
        num_o       = 2'd1;
      end
    end else if (r1.done) begin
      res0_o = '{count: r1.count, status: 1'b0, last: !trunc};
      res1_o = tr_res;
      num_o  = trunc ? 2'd2 : 2'd1;
    end else if (trunc) begin
      res0_o = tr_res;
      num_o  = 2'd1;
    end
  end

  assign st_d = last_i ? STATE_RESET : r1.st;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= STATE_RESET;
    end else if (fire_i) begin
      st_q <= st_d;
    end
  end

endmodule

// ===== rtl/ncd_result_fifo.sv =====
// Result queue: takes up to two results a cycle, hands out one a cycle while ready_i is high.
// Depends on ncd_pkg.
module ncd_result_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [1:0]    push_num_i,
  input  ncd_pkg::res_t push0_i,
  input  ncd_pkg::res_t push1_i,
  output logic          room2_o,
  output logic          valid_o,
  input  logic          ready_i,
  output ncd_pkg::res_t head_o,
  output logic [ncd_pkg::RES_CNT_W-1:0] fill_o
);
  import ncd_pkg::*;

  res_t                 mem_q [RES_DEPTH];
  logic [RES_PTR_W-1:0] wr_q, rd_q;
  logic [RES_CNT_W-1:0] cnt_q, cnt_d;
  logic                 pop;
  logic [RES_PTR_W-1:0] wr_nx;

  assign valid_o = (cnt_q != '0);
  assign pop     = valid_o && ready_i;
  assign head_o  = mem_q[rd_q];
  assign fill_o  = cnt_q;
  assign wr_nx   = wr_q + RES_PTR_W'(1);
  // room for two after this cycle's pop (a full queue never reports room)
  assign room2_o = (cnt_q <= RES_CNT_W'(RES_DEPTH - 2)) ||
                   ((cnt_q == RES_CNT_W'(RES_DEPTH - 1)) && pop);
  assign cnt_d   = cnt_q + RES_CNT_W'(push_num_i) - RES_CNT_W'(pop);

  always_ff @(posedge clk_i) begin
    if (push_num_i != 2'd0) mem_q[wr_q] <= push0_i;
    if (push_num_i == 2'd2) mem_q[wr_nx] <= push1_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + RES_PTR_W'(push_num_i);
      if (pop) rd_q <= rd_q + RES_PTR_W'(1);
      cnt_q <= cnt_d;
    end
  end

endmodule
